// ----- rtl/qdp_pkg.sv -----
package qdp_pkg;

	localparam int ENCODERS_DEF = 8;

	localparam int IDX_W      = 3;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS    = 2'd3;

	localparam logic [7:0]  DEBOUNCE_RESET = 8'd5;
	localparam logic [15:0] PULSE_RESET    = 16'd50;
	localparam logic [15:0] GAP_RESET      = 16'd15;
	localparam logic [3:0]  STEPS_RESET    = 4'd4;

	localparam logic [7:0] QUEUE_MAX = 8'hFF;
	localparam logic [1:0] PHASE_IDLE = 2'd3;

	typedef struct packed {
		logic [1:0]        prev_phase;
		logic signed [4:0] step_acc;
		logic [7:0]        pend_cw;
		logic [7:0]        pend_ccw;
		logic [31:0]       cw_off;
		logic [31:0]       ccw_off;
		logic [31:0]       cw_ready;
		logic [31:0]       ccw_ready;
		logic [31:0]       push_change;
		logic              push_raw;
		logic              push_stable;
	} enc_state_t;

	localparam enc_state_t ENC_STATE_RESET = '{prev_phase: PHASE_IDLE, default: '0};

	// indexed by {previous phase, phase}, two's complement step
	localparam logic signed [1:0] STEP_TABLE [16] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0,
		2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1,
		2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

endpackage

// ----- rtl/qdp_sample_if.sv -----
interface qdp_sample_if import qdp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  encoder_index;
	logic [TIME_W-1:0] now;
	logic              pin_a;
	logic              pin_b;
	logic              push_level;

	modport source (output valid, encoder_index, now, pin_a, pin_b, push_level, input ready);
	modport sink (input valid, encoder_index, now, pin_a, pin_b, push_level, output ready);
endinterface

// ----- rtl/qdp_result_if.sv -----
interface qdp_result_if import qdp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] which_encoder;
	logic             cw_active;
	logic             ccw_active;
	logic             push_pressed;

	modport source (output valid, which_encoder, cw_active, ccw_active, push_pressed,
		input ready);
	modport sink (input valid, which_encoder, cw_active, ccw_active, push_pressed,
		output ready);
endinterface

// ----- rtl/qdp_cfg_if.sv -----
interface qdp_cfg_if import qdp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/qdp_ram.sv -----
module qdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/quadrature_detent_pulse_queue.sv -----
// Per-encoder quadrature decoder with detent pulse queues and a debounced push switch.
// One scan sample is taken every cycle, back to back, for any mix of encoders, while
// the output side does not stall; a result passes the stage 1 and output registers
// and waits there until the output side takes it. All per-encoder state sits in one
// RAM of ENCODERS entries that is read when a sample is taken and written back when
// the sample leaves stage 1; a sample for the same encoder as the one just ahead of
// it takes that state from a bypass register. A valid flag per entry makes unwritten
// entries read as the reset state, so no clearing pass runs after reset. Samples with
// an index at or beyond ENCODERS leave state untouched and report all flags low.
module quadrature_detent_pulse_queue import qdp_pkg::*; #(
	parameter int ENCODERS = ENCODERS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	qdp_cfg_if.sink      cfg,
	qdp_sample_if.sink   sample,
	qdp_result_if.source result
);

	localparam int AW = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;
	localparam int SW = $bits(enc_state_t);

	typedef struct packed {
		logic        active;
		logic [7:0]  pend;
		logic [31:0] off;
		logic [31:0] ready;
	} pulse_t;

	// config registers
	logic [7:0]  debounce_q;
	logic [15:0] pulse_q;
	logic [15:0] gap_q;
	logic [3:0]  steps_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			pulse_q    <= PULSE_RESET;
			gap_q      <= GAP_RESET;
			steps_q    <= STEPS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DEBOUNCE: debounce_q <= cfg.data[7:0];
				REG_PULSE:    pulse_q    <= cfg.data;
				REG_GAP:      gap_q      <= cfg.data;
				REG_STEPS:    steps_q    <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// stage 1 registers
	logic              s1_valid_q;
	logic [IDX_W-1:0]  idx_s1;
	logic [AW-1:0]     addr_s1;
	logic              inr_s1;
	logic [TIME_W-1:0] now_s1;
	logic [1:0]        phase_s1;
	logic              push_s1;
	logic              vld_s1;
	logic              fwd_s1;
	enc_state_t        fwd_st_q;

	logic              out_valid_q;
	logic              s1_adv;
	logic              accept;
	logic [AW-1:0]     rd_addr;
	logic              rd_inr;
	logic              vld_q [ENCODERS];
	logic [SW-1:0]     ram_rdata;
	enc_state_t        st_cur;
	enc_state_t        st_new;
	pulse_t            cw_res;
	pulse_t            ccw_res;

	assign s1_adv       = s1_valid_q && (!out_valid_q || result.ready);
	assign sample.ready = !s1_valid_q || s1_adv;
	assign accept       = sample.valid && sample.ready;
	assign rd_addr      = AW'(sample.encoder_index);
	assign rd_inr       = 32'(sample.encoder_index) < ENCODERS;

	qdp_ram #(
		.WIDTH(SW),
		.DEPTH(ENCODERS)
	) u_state_ram (
		.clk  (clk),
		.we   (s1_adv && inr_s1),
		.waddr(addr_s1),
		.wdata(st_new),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
			vld_s1     <= 1'b0;
			for (int i = 0; i < ENCODERS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				// entry written at this edge is not yet in the ram read data
				fwd_s1     <= s1_adv && inr_s1 && (addr_s1 == rd_addr);
				vld_s1     <= rd_inr ? vld_q[rd_addr] : 1'b0;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv && inr_s1) begin
				vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= sample.encoder_index;
			addr_s1  <= rd_addr;
			inr_s1   <= rd_inr;
			now_s1   <= sample.now;
			phase_s1 <= {sample.pin_a, sample.pin_b};
			push_s1  <= ~sample.push_level;
			fwd_st_q <= st_new;
		end
	end

	function automatic pulse_t drive(input logic [31:0] off, input logic [31:0] rdy,
		input logic [7:0] pend, input logic [31:0] now, input logic [15:0] plen,
		input logic [15:0] glen);
		pulse_t      r;
		logic [31:0] d_off;
		logic [31:0] d_rdy;
		d_off = off - now;
		d_rdy = now - rdy;
		r.active = 1'b0;
		r.pend   = pend;
		r.off    = off;
		r.ready  = rdy;
		if (d_off != '0 && !d_off[31]) begin
			r.active = 1'b1;
		end else if (pend != '0 && !d_rdy[31]) begin
			r.active = 1'b1;
			r.pend   = pend - 8'd1;
			r.off    = now + 32'(plen);
			r.ready  = now + 32'(plen) + 32'(glen);
		end
		return r;
	endfunction

	always_comb begin
		logic signed [5:0] thr;
		logic signed [5:0] sum;
		logic signed [1:0] step;
		logic [31:0]       held;
		st_cur = fwd_s1 ? fwd_st_q : (vld_s1 ? enc_state_t'(ram_rdata) : ENC_STATE_RESET);
		st_new = st_cur;
		thr    = (steps_q == '0) ? 6'sd1 : $signed({2'b00, steps_q});
		step   = STEP_TABLE[{st_cur.prev_phase, phase_s1}];
		sum    = $signed({st_cur.step_acc[4], st_cur.step_acc})
			+ $signed({{4{step[1]}}, step});
		if (phase_s1 != st_cur.prev_phase) begin
			if (sum >= thr) begin
				if (st_cur.pend_cw != QUEUE_MAX) begin
					st_new.pend_cw = st_cur.pend_cw + 8'd1;
				end
				st_new.step_acc = '0;
			end else if (sum <= -thr) begin
				if (st_cur.pend_ccw != QUEUE_MAX) begin
					st_new.pend_ccw = st_cur.pend_ccw + 8'd1;
				end
				st_new.step_acc = '0;
			end else begin
				st_new.step_acc = sum[4:0];
			end
			st_new.prev_phase = phase_s1;
		end

		cw_res  = drive(st_cur.cw_off, st_cur.cw_ready, st_new.pend_cw, now_s1,
			pulse_q, gap_q);
		ccw_res = drive(st_cur.ccw_off, st_cur.ccw_ready, st_new.pend_ccw, now_s1,
			pulse_q, gap_q);
		st_new.pend_cw   = cw_res.pend;
		st_new.cw_off    = cw_res.off;
		st_new.cw_ready  = cw_res.ready;
		st_new.pend_ccw  = ccw_res.pend;
		st_new.ccw_off   = ccw_res.off;
		st_new.ccw_ready = ccw_res.ready;

		// push debounce, active low pin already inverted
		held = now_s1 - st_cur.push_change;
		if (push_s1 != st_cur.push_raw) begin
			st_new.push_raw    = push_s1;
			st_new.push_change = now_s1;
		end else if (push_s1 != st_cur.push_stable) begin
			if (held >= {24'b0, debounce_q}) begin
				st_new.push_stable = push_s1;
			end
		end
	end

	// output register
	logic [IDX_W-1:0] which_q;
	logic             cw_q;
	logic             ccw_q;
	logic             push_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			which_q <= idx_s1;
			cw_q    <= inr_s1 && cw_res.active;
			ccw_q   <= inr_s1 && ccw_res.active;
			push_q  <= inr_s1 && st_new.push_stable;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.which_encoder = which_q;
	assign result.cw_active     = cw_q;
	assign result.ccw_active    = ccw_q;
	assign result.push_pressed  = push_q;

endmodule
